// File: rtl/core/rfbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfbd_pkg
// Shared constants for the radial falloff brightness deviation block.
// ----------------------------------------------------------------------------
package rfbd_pkg;

  localparam int COORD_BITS_DEF = 12;   // default coordinate width
  localparam int COORD_PORT     = 12;   // width of the column / row ports
  localparam int PIX_BITS       = 8;    // one color channel
  localparam int CFG_BITS       = 13;   // frame size registers
  localparam int CFG_IDX_BITS   = 1;
  localparam int QUOT_BITS      = 8;    // quotient bits of the final divide
  localparam int FRAC_BITS      = 8;    // fixed point fraction bits

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic [PIX_BITS-1:0] FULL_SCALE = 8'd255;

endpackage

// File: rtl/core/rfbd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfbd_sqrt_cell
// One digit cell of an integer square root: consumes two radicand bits per
// lane and decides one root bit, then registers everything for the next cell.
// ----------------------------------------------------------------------------
module rfbd_sqrt_cell #(
  parameter int N  = 8,   // root bits
  parameter int L  = 1,   // lanes
  parameter int TW = 8    // side data width
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      vld_i,
  input  logic [TW-1:0]             tag_i,
  input  logic [L-1:0][2*N-1:0]     val_i,
  input  logic [L-1:0][N+2:0]       rem_i,
  input  logic [L-1:0][N-1:0]       root_i,
  output logic                      vld_o,
  output logic [TW-1:0]             tag_o,
  output logic [L-1:0][2*N-1:0]     val_o,
  output logic [L-1:0][N+2:0]       rem_o,
  output logic [L-1:0][N-1:0]       root_o
);

  logic [L-1:0][N+2:0] rem_next;
  logic [L-1:0][N-1:0] root_next;

  // trial subtract of (root << 2 | 1) from the shifted remainder
  always_comb begin
    logic [N+2:0] rs;
    logic [N+2:0] trial;
    for (int l = 0; l < L; l++) begin
      rs    = {rem_i[l][N:0], val_i[l][2*N-1:2*N-2]};
      trial = {1'b0, root_i[l], 2'b01};
      if (rs >= trial) begin
        rem_next[l]  = rs - trial;
        root_next[l] = {root_i[l][N-2:0], 1'b1};
      end else begin
        rem_next[l]  = rs;
        root_next[l] = {root_i[l][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    tag_o <= tag_i;
    for (int l = 0; l < L; l++) begin
      val_o[l] <= {val_i[l][2*N-3:0], 2'b00};
    end
    rem_o  <= rem_next;
    root_o <= root_next;
  end

endmodule

// File: rtl/core/rfbd_sqrt_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfbd_sqrt_chain
// Row of N square root cells; one root bit per cell, one item per cycle.
// ----------------------------------------------------------------------------
module rfbd_sqrt_chain #(
  parameter int N  = 8,
  parameter int L  = 1,
  parameter int TW = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  vld_i,
  input  logic [TW-1:0]         tag_i,
  input  logic [L-1:0][2*N-1:0] val_i,
  output logic                  vld_o,
  output logic [TW-1:0]         tag_o,
  output logic [L-1:0][N-1:0]   root_o
);

  logic                  vld  [N+1];
  logic [TW-1:0]         tag  [N+1];
  logic [L-1:0][2*N-1:0] val  [N+1];
  logic [L-1:0][N+2:0]   rem  [N+1];
  logic [L-1:0][N-1:0]   root [N+1];

  assign vld[0]  = vld_i;
  assign tag[0]  = tag_i;
  assign val[0]  = val_i;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rfbd_sqrt_cell #(.N(N), .L(L), .TW(TW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .vld_i  (vld[i]),
      .tag_i  (tag[i]),
      .val_i  (val[i]),
      .rem_i  (rem[i]),
      .root_i (root[i]),
      .vld_o  (vld[i+1]),
      .tag_o  (tag[i+1]),
      .val_o  (val[i+1]),
      .rem_o  (rem[i+1]),
      .root_o (root[i+1])
    );
  end

  assign vld_o  = vld[N];
  assign tag_o  = tag[N];
  assign root_o = root[N];

endmodule

// File: rtl/core/rfbd_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfbd_div_cell
// One restoring divide cell: decides quotient bit SH by comparing the
// running remainder with the divisor shifted left by SH.
// ----------------------------------------------------------------------------
module rfbd_div_cell #(
  parameter int MW = 24,  // remainder width
  parameter int DW = 16,  // divisor width
  parameter int SH = 0,   // quotient bit handled here
  parameter int TW = 9
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               vld_i,
  input  logic                               live_i,
  input  logic [TW-1:0]                      tag_i,
  input  logic [MW-1:0]                      rem_i,
  input  logic [DW-1:0]                      dvs_i,
  input  logic [rfbd_pkg::QUOT_BITS-1:0]     q_i,
  output logic                               vld_o,
  output logic                               live_o,
  output logic [TW-1:0]                      tag_o,
  output logic [MW-1:0]                      rem_o,
  output logic [DW-1:0]                      dvs_o,
  output logic [rfbd_pkg::QUOT_BITS-1:0]     q_o
);
  import rfbd_pkg::*;

  localparam logic [QUOT_BITS-1:0] QBIT = QUOT_BITS'(1) << SH;

  logic [MW-1:0] step;
  assign step = MW'(dvs_i) << SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  // compare and conditional subtract
  always_ff @(posedge clk) begin
    live_o <= live_i;
    tag_o  <= tag_i;
    dvs_o  <= dvs_i;
    if (rem_i >= step) begin
      rem_o <= rem_i - step;
      q_o   <= q_i | QBIT;
    end else begin
      rem_o <= rem_i;
      q_o   <= q_i;
    end
  end

  // remainder must fall below the step just taken when dividing for real
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld_o && live_o |-> rem_o < (MW'(dvs_o) << SH))
    else $error("divide remainder above step");

  // bits below this one are still undecided
  a_low_zero: assert property (@(posedge clk) disable iff (rst)
    vld_o && $past(vld_i && q_i == '0) |-> (q_o & (QBIT - QUOT_BITS'(1))) == '0)
    else $error("low quotient bits set early");

  a_rst_clear: assert property (@(posedge clk)
    $past(rst) |-> !vld_o)
    else $error("valid after reset");

endmodule

// File: rtl/core/radial_falloff_brightness_diff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_falloff_brightness_diff
// Deviation of a pixel's brightness from a radial falloff from frame centre.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; busy is always low, each root and divide
//   cell takes a new item every cycle.
// Reset: synchronous; clears all valid flags and loads 640 x 480 frame size.
// The receiver cannot stall: each result shows for one cycle on done.
// ----------------------------------------------------------------------------
module radial_falloff_brightness_diff #(
  parameter int COORD_BITS = rfbd_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [rfbd_pkg::PIX_BITS-1:0]       red,
  input  logic [rfbd_pkg::PIX_BITS-1:0]       green,
  input  logic [rfbd_pkg::PIX_BITS-1:0]       blue,
  input  logic [rfbd_pkg::COORD_PORT-1:0]     column,
  input  logic [rfbd_pkg::COORD_PORT-1:0]     row,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rfbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rfbd_pkg::CFG_BITS-1:0]       cfg_data,
  output logic                                done,
  output logic [rfbd_pkg::PIX_BITS-1:0]       depth_value
);
  import rfbd_pkg::*;

  localparam int CW  = (COORD_BITS < COORD_PORT) ? COORD_BITS : COORD_PORT;
  localparam int DW  = (COORD_BITS > CFG_BITS - 1) ? COORD_BITS : CFG_BITS - 1;
  localparam int D2W = 2 * DW + 1;
  localparam int R1  = (D2W + 2 * FRAC_BITS + 1) / 2;
  localparam int R2  = (R1 + FRAC_BITS + 1) / 2;
  localparam int NW  = R2 + 10;          // signed numerator
  localparam int MW  = R2 + 8;           // numerator magnitude
  localparam int TW1 = PIX_BITS;
  localparam int TW2 = PIX_BITS + 1;     // brightness and degenerate flag

  // configuration registers
  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: brightness and offsets from the centre
  logic [DW-1:0]       col_m, row_m, cx, cy;
  logic                s0_vld;
  logic [PIX_BITS-1:0] s0_bright, bright_next;
  logic [DW-1:0]       s0_dx, s0_dy, s0_cx, s0_cy;

  assign col_m = DW'(column[CW-1:0]);
  assign row_m = DW'(row[CW-1:0]);
  assign cx    = DW'(frame_width[CFG_BITS-1:1]);
  assign cy    = DW'(frame_height[CFG_BITS-1:1]);

  always_comb begin
    bright_next = red;
    if (green > bright_next) bright_next = green;
    if (blue > bright_next) bright_next = blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_bright <= bright_next;
    s0_dx     <= (col_m > cx) ? col_m - cx : cx - col_m;
    s0_dy     <= (row_m > cy) ? row_m - cy : cy - row_m;
    s0_cx     <= cx;
    s0_cy     <= cy;
  end

  // stage 1: squares
  logic                s1_vld;
  logic [PIX_BITS-1:0] s1_bright;
  logic [2*DW-1:0]     s1_dx2, s1_dy2, s1_cx2, s1_cy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_bright <= s0_bright;
    s1_dx2    <= s0_dx * s0_dx;
    s1_dy2    <= s0_dy * s0_dy;
    s1_cx2    <= s0_cx * s0_cx;
    s1_cy2    <= s0_cy * s0_cy;
  end

  // first root: distance in 8-bit fixed point, pixel and centre lanes
  logic [D2W-1:0]         d2, c2;
  logic [1:0][2*R1-1:0]   r1_in;
  logic                   r1_vld;
  logic [TW1-1:0]         r1_tag;
  logic [1:0][R1-1:0]     r1_root;

  assign d2       = D2W'(s1_dx2) + D2W'(s1_dy2);
  assign c2       = D2W'(s1_cx2) + D2W'(s1_cy2);
  assign r1_in[0] = (2*R1)'(d2) << (2 * FRAC_BITS);
  assign r1_in[1] = (2*R1)'(c2) << (2 * FRAC_BITS);

  rfbd_sqrt_chain #(.N(R1), .L(2), .TW(TW1)) u_root1 (
    .clk    (clk),
    .rst    (rst),
    .vld_i  (s1_vld),
    .tag_i  (s1_bright),
    .val_i  (r1_in),
    .vld_o  (r1_vld),
    .tag_o  (r1_tag),
    .root_o (r1_root)
  );

  // second root: square root of the distance
  logic [1:0][2*R2-1:0] r2_in;
  logic                 r2_vld;
  logic [TW1-1:0]       r2_tag;
  logic [1:0][R2-1:0]   r2_root;

  assign r2_in[0] = (2*R2)'(r1_root[0]) << FRAC_BITS;
  assign r2_in[1] = (2*R2)'(r1_root[1]) << FRAC_BITS;

  rfbd_sqrt_chain #(.N(R2), .L(2), .TW(TW1)) u_root2 (
    .clk    (clk),
    .rst    (rst),
    .vld_i  (r1_vld),
    .tag_i  (r1_tag),
    .val_i  (r2_in),
    .vld_o  (r2_vld),
    .tag_o  (r2_tag),
    .root_o (r2_root)
  );

  // stage A: b*sD and 255*(sd - sD)
  logic                 sa_vld;
  logic [PIX_BITS-1:0]  sa_bright;
  logic [R2-1:0]        sa_sdc;
  logic [NW-1:0]        sa_prod;
  logic signed [NW-1:0] sa_fall;
  logic signed [NW-1:0] diff;

  assign diff = $signed(NW'(r2_root[0])) - $signed(NW'(r2_root[1]));

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_vld <= 1'b0;
    end else begin
      sa_vld <= r2_vld;
    end
  end

  always_ff @(posedge clk) begin
    sa_bright <= r2_tag;
    sa_sdc    <= r2_root[1];
    sa_prod   <= NW'(r2_tag) * NW'(r2_root[1]);
    sa_fall   <= (diff <<< FRAC_BITS) - diff;
  end

  // stage B: magnitude of the numerator
  logic                 sb_vld;
  logic [PIX_BITS-1:0]  sb_bright;
  logic [R2-1:0]        sb_sdc;
  logic [MW-1:0]        sb_mag;
  logic signed [NW-1:0] num;

  assign num = $signed(sa_prod) + sa_fall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_vld <= 1'b0;
    end else begin
      sb_vld <= sa_vld;
    end
  end

  always_ff @(posedge clk) begin
    sb_bright <= sa_bright;
    sb_sdc    <= sa_sdc;
    sb_mag    <= num[NW-1] ? MW'(-num) : MW'(num);
  end

  // stage C: saturation and degenerate centre checks
  logic                sc_vld;
  logic [TW2-1:0]      sc_tag;
  logic                sc_live;
  logic [MW-1:0]       sc_mag;
  logic [R2-1:0]       sc_sdc;
  logic                sat, zero;

  assign zero = (sb_sdc == '0);
  assign sat  = sb_mag >= (MW'(sb_sdc) << QUOT_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_vld <= 1'b0;
    end else begin
      sc_vld <= sb_vld;
    end
  end

  always_ff @(posedge clk) begin
    sc_tag  <= {sb_bright, zero};
    sc_live <= !zero && !sat;
    sc_mag  <= sb_mag;
    sc_sdc  <= sb_sdc;
  end

  // divide chain, one quotient bit per cell, high bit first
  logic                 dv_vld  [QUOT_BITS+1];
  logic                 dv_live [QUOT_BITS+1];
  logic [TW2-1:0]       dv_tag  [QUOT_BITS+1];
  logic [MW-1:0]        dv_rem  [QUOT_BITS+1];
  logic [R2-1:0]        dv_dvs  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] dv_q    [QUOT_BITS+1];

  assign dv_vld[0]  = sc_vld;
  assign dv_live[0] = sc_live;
  assign dv_tag[0]  = sc_tag;
  assign dv_rem[0]  = sc_mag;
  assign dv_dvs[0]  = sc_sdc;
  assign dv_q[0]    = '0;

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_div
    rfbd_div_cell #(.MW(MW), .DW(R2), .SH(QUOT_BITS - 1 - i), .TW(TW2)) u_div (
      .clk    (clk),
      .rst    (rst),
      .vld_i  (dv_vld[i]),
      .live_i (dv_live[i]),
      .tag_i  (dv_tag[i]),
      .rem_i  (dv_rem[i]),
      .dvs_i  (dv_dvs[i]),
      .q_i    (dv_q[i]),
      .vld_o  (dv_vld[i+1]),
      .live_o (dv_live[i+1]),
      .tag_o  (dv_tag[i+1]),
      .rem_o  (dv_rem[i+1]),
      .dvs_o  (dv_dvs[i+1]),
      .q_o    (dv_q[i+1])
    );
  end

  // output register: degenerate centre passes brightness, overflow saturates
  logic [TW2-1:0] fin_tag;
  assign fin_tag = dv_tag[QUOT_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[QUOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_tag[0]) begin
      depth_value <= fin_tag[TW2-1:1];
    end else if (!dv_live[QUOT_BITS]) begin
      depth_value <= FULL_SCALE;
    end else begin
      depth_value <= dv_q[QUOT_BITS];
    end
  end

endmodule

// File: tb/tb_radial_falloff_brightness_diff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radial_falloff_brightness_diff
// Drives pixels with random gaps through the radial falloff deviation block,
// changes frame size between phases and checks every depth value against an
// expected value from a fixed-point predictor in this bench or the directed table.
// ----------------------------------------------------------------------------
module tb_radial_falloff_brightness_diff;
  import rfbd_pkg::*;

  localparam int LATENCY   = 49;
  localparam int SETTLE    = LATENCY + 20;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 550;
  localparam int N_DIRECT  = 14;

  typedef struct {
    logic [7:0]  r, g, b;
    logic [11:0] col, rw;
    int          want;     // -1: use predictor
  } pixel_row_t;

  logic                    clk, rst, start, busy;
  logic [PIX_BITS-1:0]     red, green, blue;
  logic [COORD_PORT-1:0]   column, row;
  logic                    cfg_valid, cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;
  logic                    done;
  logic [PIX_BITS-1:0]     depth_value;

  logic [12:0] width_q, height_q;
  logic [7:0]  depth_fifo[$];
  int          n_err;
  int          wdog;
  bit          no_idle;

  radial_falloff_brightness_diff DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // bitwise integer square root
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned acc, bitv;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v  -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  // fourth root of a squared distance, 8 fraction bits
  function automatic longint unsigned quarter_root(longint unsigned d2);
    return int_sqrt(int_sqrt(d2 << 16) << 8);
  endfunction

  function automatic logic [7:0] predict_depth(logic [7:0] r, logic [7:0] g,
                                               logic [7:0] b, logic [11:0] c,
                                               logic [11:0] y);
    longint unsigned cx, cy, dx, dy, sd, sc, mag, bright, q;
    longint          num;
    cx = width_q >> 1;
    cy = height_q >> 1;
    bright = r;
    if (g > bright) bright = g;
    if (b > bright) bright = b;
    dx = (c > cx) ? c - cx : cx - c;
    dy = (y > cy) ? y - cy : cy - y;
    sc = quarter_root(cx * cx + cy * cy);
    sd = quarter_root(dx * dx + dy * dy);
    if (sc == 0) return bright[7:0];
    num = longint'(bright * sc) - 255 * (longint'(sc) - longint'(sd));
    mag = (num < 0) ? -num : num;
    q = mag / sc;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) wdog <= 0;
      else wdog <= wdog + 1;
      if (done) begin
        if (depth_fifo.size() == 0) begin
          $error("depth_value: unexpected result %0d", depth_value);
          n_err++;
        end else begin
          if (depth_fifo[0] !== depth_value) begin
            $error("depth_value: expected %0d actual %0d", depth_fifo[0], depth_value);
            n_err++;
          end
          void'(depth_fifo.pop_front());
        end
      end
      if (wdog >= WDOG_MAX) begin
        $display("watchdog expired");
        $display("tb_radial_falloff_brightness_diff: errors");
        $finish;
      end
    end
  end

  // within a burst, start drops only when a gap is taken
  task automatic idle_gap();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // one pixel transfer; expected value queued when accepted, start left high
  task automatic send_pixel(pixel_row_t p);
    logic [7:0] exp_v;
    exp_v = (p.want >= 0) ? p.want[7:0] : predict_depth(p.r, p.g, p.b, p.col, p.rw);
    start <= 1'b1;
    red <= p.r; green <= p.g; blue <= p.b; column <= p.col; row <= p.rw;
    @(posedge clk);
    while (busy) @(posedge clk);
    depth_fifo = {depth_fifo, exp_v};
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (depth_fifo.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FRAME_WIDTH) width_q = val;
    else height_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_burst(int count);
    pixel_row_t p;
    for (int i = 0; i < count; i++) begin
      p.r = 8'($urandom); p.g = 8'($urandom); p.b = 8'($urandom);
      // mostly near the frame, sometimes anywhere in the coordinate range
      if ($urandom_range(0, 3) == 0) begin
        p.col = 12'($urandom); p.rw = 12'($urandom);
      end else begin
        p.col = 12'($urandom_range(0, width_q));
        p.rw  = 12'($urandom_range(0, height_q));
      end
      p.want = -1;
      send_pixel(p);
      idle_gap();
    end
  endtask

  pixel_row_t dir_tab[N_DIRECT];

  initial begin
    logic [12:0] w_set[6];
    logic [12:0] h_set[6];
    rst = 1'b1; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    red = '0; green = '0; blue = '0; column = '0; row = '0;
    n_err = 0; wdog = 0; no_idle = 1'b0;
    width_q = FRAME_WIDTH_RST; height_q = FRAME_HEIGHT_RST;

    // at centre E = 255 - b; at origin E = b
    dir_tab[0]  = '{8'd255, 8'd0,   8'd0,   12'd320,  12'd240,  0};
    dir_tab[1]  = '{8'd0,   8'd0,   8'd0,   12'd320,  12'd240,  255};
    dir_tab[2]  = '{8'd0,   8'd0,   8'd0,   12'd0,    12'd0,    0};
    dir_tab[3]  = '{8'd0,   8'd255, 8'd0,   12'd0,    12'd0,    255};
    dir_tab[4]  = '{8'd0,   8'd0,   8'd255, 12'd320,  12'd240,  0};
    dir_tab[5]  = '{8'd0,   8'd0,   8'd0,   12'd4095, 12'd4095, -1};
    dir_tab[6]  = '{8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095, 255};
    dir_tab[7]  = '{8'd170, 8'd85,  8'd1,   12'd640,  12'd480,  -1};
    dir_tab[8]  = '{8'd1,   8'd2,   8'd128, 12'd2730, 12'd1365, -1};
    dir_tab[9]  = '{8'd127, 8'd127, 8'd127, 12'd319,  12'd241,  -1};
    dir_tab[10] = '{8'd64,  8'd200, 8'd32,  12'd0,    12'd480,  -1};
    dir_tab[11] = '{8'd85,  8'd170, 8'd254, 12'd640,  12'd0,    -1};
    dir_tab[12] = '{8'd255, 8'd0,   8'd0,   12'd0,    12'd0,    -1};
    dir_tab[13] = '{8'd0,   8'd0,   8'd0,   12'd2048, 12'd2048, -1};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed pixels at reset frame size
    foreach (dir_tab[i]) send_pixel(dir_tab[i]);

    // degenerate centre: output is brightness
    drain();
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    for (int i = 0; i < 6; i++) send_pixel('{8'($urandom), 8'($urandom), 8'($urandom),
                                            12'($urandom), 12'($urandom), -1});
    random_burst(20);

    // frame sizes swept, extremes included
    w_set = '{13'd2, 13'd4096, 13'd8191, 13'd2, 13'd1000, 13'd640};
    h_set = '{13'd2, 13'd4096, 13'd8191, 13'd4096, 13'd3, 13'd480};
    for (int k = 0; k < 6; k++) begin
      drain();
      write_reg(REG_FRAME_WIDTH, w_set[k]);
      write_reg(REG_FRAME_HEIGHT, h_set[k]);
      if (k == 5) no_idle = 1'b1;
      random_burst(N_RANDOM / 6);
    end

    drain();
    if (n_err == 0) $display("tb_radial_falloff_brightness_diff: clean");
    else $display("tb_radial_falloff_brightness_diff: errors");
    $finish;
  end

endmodule
